>>> hdl/mmsf_pkg.sv
// Package for the multi-mode sensor filter: configuration codes and the
// fixed-point IIR coefficients. No dependencies.
package mmsf_pkg;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IDX_KIND  = 2'd0;
    localparam t_cfg_idx CFG_IDX_ORDER = 2'd1;

    // Filter kinds (codes 5..7 mean no filter, output zero)
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_CHEB   = 3'd0;
    localparam t_kind KIND_BESSEL = 3'd1;
    localparam t_kind KIND_MEDIAN = 3'd2;
    localparam t_kind KIND_FAST   = 3'd3;
    localparam t_kind KIND_SMOOTH = 3'd4;

    // IIR orders (0 and 3 mean no filter)
    typedef logic [1:0] t_order;
    localparam t_order ORDER_ONE = 2'd1;
    localparam t_order ORDER_TWO = 2'd2;

    localparam int CFG_DATA_W = 3;

    // IIR coefficients, Q-format, signed
    localparam int COEF_W = 24;
    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef CHEB1_X   = 24'sd3269048;
    localparam t_coef CHEB1_T0  = 24'sd3701023;
    localparam t_coef CHEB1_RND = 24'sd1048576;
    localparam t_coef BES1_X    = 24'sd2057199;
    localparam t_coef BES1_T0   = 24'sd1068552;
    localparam t_coef BES1_RND  = 24'sd524288;
    localparam t_coef CHEB2_X   = 24'sd662828;
    localparam t_coef CHEB2_T0  = -24'sd540791;
    localparam t_coef CHEB2_T1  = 24'sd628977;
    localparam t_coef BES2_X    = 24'sd759505;
    localparam t_coef BES2_T0   = -24'sd1011418;
    localparam t_coef BES2_T1   = 24'sd921678;
    localparam t_coef ORD2_RND  = 24'sd262144;

    // Shift amounts
    typedef logic [4:0] t_shift;

endpackage

>>> hdl/mmsf_iir.sv
// First/second-order Chebyshev and Bessel low-pass datapath (combinational).
// Depends on mmsf_pkg.
module mmsf_iir #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_bessel,
    input  logic                           i_order_two,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_t0,
    input  logic signed [SAMPLE_WIDTH-1:0] i_t1,
    output logic signed [SAMPLE_WIDTH-1:0] o_acc,
    output logic        [SAMPLE_WIDTH-1:0] o_filtered
);

    localparam int AW = SAMPLE_WIDTH + 26;

    mmsf_pkg::t_coef  w_cx, w_c0, w_c1, w_rnd;
    mmsf_pkg::t_shift w_sx, w_s0, w_s1, w_sa;

    logic signed [AW-1:0] w_x, w_t0, w_t1;
    logic signed [AW-1:0] w_mx, w_m0, w_m1;
    logic signed [AW-1:0] w_sum, w_acc;

    // Coefficient and shift selection per filter flavor
    always_comb begin
        w_c1 = '0;
        w_s1 = '0;
        if (i_order_two) begin
            w_rnd = mmsf_pkg::ORD2_RND;
            w_sa  = 5'd19;
            if (i_bessel) begin
                w_cx = mmsf_pkg::BES2_X;  w_sx = 5'd4;
                w_c0 = mmsf_pkg::BES2_T0; w_s0 = 5'd3;
                w_c1 = mmsf_pkg::BES2_T1; w_s1 = 5'd1;
            end else begin
                w_cx = mmsf_pkg::CHEB2_X;  w_sx = 5'd4;
                w_c0 = mmsf_pkg::CHEB2_T0; w_s0 = 5'd1;
                w_c1 = mmsf_pkg::CHEB2_T1; w_s1 = 5'd0;
            end
        end else begin
            if (i_bessel) begin
                w_cx = mmsf_pkg::BES1_X;  w_sx = 5'd3;
                w_c0 = mmsf_pkg::BES1_T0; w_s0 = 5'd1;
                w_rnd = mmsf_pkg::BES1_RND; w_sa = 5'd20;
            end else begin
                w_cx = mmsf_pkg::CHEB1_X;  w_sx = 5'd2;
                w_c0 = mmsf_pkg::CHEB1_T0; w_s0 = 5'd3;
                w_rnd = mmsf_pkg::CHEB1_RND; w_sa = 5'd21;
            end
        end
    end

    // Three constant-coefficient products, floor shifts, rounding, final shift
    always_comb begin
        w_x   = AW'(i_x);
        w_t0  = AW'(i_t0);
        w_t1  = AW'(i_t1);
        w_mx  = w_x  * AW'(w_cx);
        w_m0  = w_t0 * AW'(w_c0);
        w_m1  = w_t1 * AW'(w_c1);
        w_sum = (w_mx >>> w_sx) + (w_m0 >>> w_s0) + (w_m1 >>> w_s1) + AW'(w_rnd);
        w_acc = w_sum >>> w_sa;
    end

    assign o_acc = w_acc[SAMPLE_WIDTH-1:0];

    // Output sum wraps to the sample width
    always_comb begin
        if (i_order_two) begin
            o_filtered = SAMPLE_WIDTH'(i_t0) + SAMPLE_WIDTH'(o_acc)
                       + SAMPLE_WIDTH'({i_t1, 1'b0});
        end else begin
            o_filtered = SAMPLE_WIDTH'(i_t0) + SAMPLE_WIDTH'(o_acc);
        end
    end

endmodule

>>> hdl/mmsf_track.sv
// Fast and smooth level trackers: next tracker value and step counter
// (combinational). Depends on mmsf_pkg only through the top level.
module mmsf_track #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_smooth,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_tracker,
    input  logic        [3:0]              i_step_count,
    output logic signed [SAMPLE_WIDTH-1:0] o_tracker,
    output logic        [3:0]              o_step_count
);

    // Wide enough for the largest move past either end of the sample range
    localparam int HW = SAMPLE_WIDTH + 12;
    localparam logic [3:0] STEP_LIMIT = 4'd10;

    logic signed [HW-1:0] w_x, w_h;
    logic signed [HW-1:0] w_f1, w_f2, w_f3, w_f4, w_fast;
    logic signed [HW-1:0] w_smooth;
    logic        [3:0]    w_sc;

    assign w_x = HW'(i_x);
    assign w_h = HW'(i_tracker);

    // Fast tracker: binary-weighted step chain toward the sample
    always_comb begin
        w_f1 = w_h;
        w_f2 = w_h;
        w_f3 = w_h;
        w_f4 = w_h;
        w_fast = w_h;
        if (w_x > w_h) begin
            w_f1 = (w_x > w_h  + HW'(512)) ? w_h  + HW'(512) : w_h;
            w_f2 = (w_x > w_f1 + HW'(128)) ? w_f1 + HW'(128) : w_f1;
            w_f3 = (w_x > w_f2 + HW'(32))  ? w_f2 + HW'(32)  : w_f2;
            w_f4 = (w_x > w_f3 + HW'(8))   ? w_f3 + HW'(8)   : w_f3;
            w_fast = w_f4 + HW'(1);
        end else if (w_x < w_h) begin
            w_f1 = (w_x < w_h  - HW'(512)) ? w_h  - HW'(512) : w_h;
            w_f2 = (w_x < w_f1 - HW'(128)) ? w_f1 - HW'(128) : w_f1;
            w_f3 = (w_x < w_f2 - HW'(32))  ? w_f2 - HW'(32)  : w_f2;
            w_f4 = (w_x < w_f3 - HW'(8))   ? w_f3 - HW'(8)   : w_f3;
            w_fast = w_f4 - HW'(1);
        end
    end

    // Smooth tracker: large gaps grow the jump by 8 per step
    always_comb begin
        w_sc = i_step_count;
        w_smooth = w_h;
        if (w_x > w_h) begin
            if (w_x > w_h + HW'(8)) begin
                w_sc = i_step_count + 4'd1;
                w_smooth = w_h + HW'({w_sc, 3'b000});
            end
            w_smooth = w_smooth + HW'(1);
        end else if (w_x < w_h) begin
            if (w_x < w_h - HW'(8)) begin
                w_sc = i_step_count + 4'd1;
                w_smooth = w_h - HW'({w_sc, 3'b000});
            end
            w_smooth = w_smooth - HW'(1);
        end
    end

    assign o_tracker    = i_smooth ? w_smooth[SAMPLE_WIDTH-1:0] : w_fast[SAMPLE_WIDTH-1:0];
    assign o_step_count = (w_sc > STEP_LIMIT) ? 4'd0 : w_sc;

endmodule

>>> hdl/multi_mode_sensor_filter_core.sv
// Top level of the multi-mode sensor filter: input register, filter state,
// result register. Depends on mmsf_pkg, mmsf_iir and mmsf_track.

// One sample in, one filtered sample out. The block takes a sample every
// clock cycle unless i_filtered_ready holds a waiting result back. A sample
// passes the input register, then the filter datapath into the result
// register, where it waits for i_filtered_ready while the next sample moves
// up. The throughput of one sample per cycle, stalls apart, is set by the
// state feedback: each IIR tap, tracker and step counter update is completed
// as the sample moves from input register to result register. Kind 0 is
// Chebyshev low-pass, 1 Bessel low-pass (order 1 or 2 from register 1),
// 2 median of three, 3 fast tracker, 4 smooth tracker; other kinds and IIR
// orders give zero and leave the state alone. Switching modes clears
// nothing. Write configuration only while no transaction is in flight.
module multi_mode_sensor_filter_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  mmsf_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [mmsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // sample input channel
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    // filtered output channel
    output logic                                o_filtered_valid,
    input  logic                                i_filtered_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered
);

    mmsf_pkg::t_kind  r_kind;
    mmsf_pkg::t_order r_order;

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_filtered, n_filtered;

    // Delay line: the oldest tap is always overwritten before use, so only
    // the two newer taps are stored.
    logic signed [SAMPLE_WIDTH-1:0] r_tap1, r_tap2, n_tap1, n_tap2;
    logic signed [SAMPLE_WIDTH-1:0] r_tracker, n_tracker;
    logic        [3:0]              r_step_count, n_step_count;

    logic                           w_adv;
    logic                           w_order_ok;
    logic signed [SAMPLE_WIDTH-1:0] w_iir_acc;
    logic        [SAMPLE_WIDTH-1:0] w_iir_out;
    logic signed [SAMPLE_WIDTH-1:0] w_trk;
    logic        [3:0]              w_trk_sc;
    logic signed [SAMPLE_WIDTH-1:0] w_med;
    logic signed [SAMPLE_WIDTH-1:0] w_a, w_b, w_c;

    // Handshake: the input stage moves on when the result register is free or being read
    assign w_adv          = r_in_valid && (!r_out_valid || i_filtered_ready);
    assign o_sample_ready = !r_in_valid || w_adv;
    assign o_filtered_valid = r_out_valid;
    assign o_filtered     = r_filtered;

    assign w_order_ok = (r_order == mmsf_pkg::ORDER_ONE) || (r_order == mmsf_pkg::ORDER_TWO);

    mmsf_iir #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_iir (
        .i_bessel    (r_kind == mmsf_pkg::KIND_BESSEL),
        .i_order_two (r_order == mmsf_pkg::ORDER_TWO),
        .i_x         (r_sample),
        .i_t0        (r_tap1),
        .i_t1        (r_tap2),
        .o_acc       (w_iir_acc),
        .o_filtered  (w_iir_out)
    );

    mmsf_track #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_track (
        .i_smooth     (r_kind == mmsf_pkg::KIND_SMOOTH),
        .i_x          (r_sample),
        .i_tracker    (r_tracker),
        .i_step_count (r_step_count),
        .o_tracker    (w_trk),
        .o_step_count (w_trk_sc)
    );

    // Median of the two newest stored taps and the incoming sample
    always_comb begin
        w_a = r_tap1;
        w_b = r_tap2;
        w_c = r_sample;
        if (w_c < w_b) begin
            if (w_c < w_a) begin
                w_med = (w_b < w_a) ? w_b : w_a;
            end else begin
                w_med = w_c;
            end
        end else if (w_c < w_a) begin
            w_med = w_c;
        end else begin
            w_med = (w_b < w_a) ? w_a : w_b;
        end
    end

    // Result and next state per mode
    always_comb begin
        n_filtered   = '0;
        n_tap1       = r_tap1;
        n_tap2       = r_tap2;
        n_tracker    = r_tracker;
        n_step_count = r_step_count;
        case (r_kind)
            mmsf_pkg::KIND_CHEB,
            mmsf_pkg::KIND_BESSEL: begin
                if (w_order_ok) begin
                    n_filtered = w_iir_out;
                    if (r_order == mmsf_pkg::ORDER_TWO) begin
                        // second order shifts the whole delay line
                        n_tap1 = r_tap2;
                        n_tap2 = w_iir_acc;
                    end else begin
                        n_tap1 = w_iir_acc;
                    end
                end
            end
            mmsf_pkg::KIND_MEDIAN: begin
                n_filtered = w_med;
                n_tap1     = r_tap2;
                n_tap2     = r_sample;
            end
            mmsf_pkg::KIND_FAST: begin
                n_filtered = w_trk;
                n_tracker  = w_trk;
            end
            mmsf_pkg::KIND_SMOOTH: begin
                n_filtered   = w_trk;
                n_tracker    = w_trk;
                n_step_count = w_trk_sc;
            end
            default: begin
                n_filtered = '0;
            end
        endcase
    end

    // Control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind       <= mmsf_pkg::KIND_CHEB;
            r_order      <= mmsf_pkg::ORDER_ONE;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tap1       <= '0;
            r_tap2       <= '0;
            r_tracker    <= '0;
            r_step_count <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mmsf_pkg::CFG_IDX_KIND:  r_kind  <= i_cfg_data;
                    mmsf_pkg::CFG_IDX_ORDER: r_order <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (o_sample_ready) begin
                r_in_valid <= i_sample_valid;
            end
            if (w_adv) begin
                r_out_valid  <= 1'b1;
                r_tap1       <= n_tap1;
                r_tap2       <= n_tap2;
                r_tracker    <= n_tracker;
                r_step_count <= n_step_count;
            end else if (i_filtered_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_sample_ready && i_sample_valid) begin
            r_sample <= i_sample;
        end
        if (w_adv) begin
            r_filtered <= n_filtered;
        end
    end

endmodule
